>>> hdl/fbsa_pkg.sv
// shared types, constants and codes of the fixed block slot allocator
package fbsa_pkg;

    // default pool size in slots
    localparam int SLOTS_DEFAULT = 64;

    // field widths
    localparam int TE_W     = 7;
    localparam int PAY_W    = 12;
    localparam int SLOT_W   = 6;
    localparam int OFF_W    = 18;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int STRIDE_W = PAY_W + 1;

    // largest usable slot count the table_entries register can express
    localparam int MAX_COUNT = (2 ** TE_W) - 1;

    // used bits are searched one group of this many slots per cycle
    localparam int GRP_W     = 16;
    localparam int LOG_GRP_W = 4;

    // tag word in front of each block payload
    localparam int TAG_BYTES = 4;

    // register reset values
    localparam logic [TE_W-1:0]  TE_RESET  = TE_W'(64);
    localparam logic [PAY_W-1:0] PAY_RESET = PAY_W'(64);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_BYTES = 1'b1;

    // request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_POOL     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_FREED    = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_MUL,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic grp_inc;
        logic take;
        logic ovf;
        logic free_eval;
        logic mul;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_free;
        logic found;
        logic last;
        logic out_busy;
    } t_sts;

endpackage

>>> hdl/fbsa_ctrl.sv
// controller state machine of the fixed block slot allocator
module fbsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fbsa_pkg::t_sts i_sts,
    output fbsa_pkg::t_cmd o_cmd
);

    fbsa_pkg::t_state r_state;
    fbsa_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            fbsa_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_sts.in_free ? fbsa_pkg::S_FREE : fbsa_pkg::S_SCAN;
                end
            end
            fbsa_pkg::S_SCAN: begin
                // one slot group per cycle until a free slot or the count limit
                priority if (i_sts.found) begin
                    o_cmd.take = 1'b1;
                    n_state = fbsa_pkg::S_MUL;
                end else if (i_sts.last) begin
                    o_cmd.ovf = 1'b1;
                    n_state = fbsa_pkg::S_DONE;
                end else begin
                    o_cmd.grp_inc = 1'b1;
                end
            end
            fbsa_pkg::S_FREE: begin
                o_cmd.free_eval = 1'b1;
                n_state = fbsa_pkg::S_DONE;
            end
            fbsa_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = fbsa_pkg::S_DONE;
            end
            fbsa_pkg::S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = fbsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fbsa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/fbsa_dp.sv
// datapath of the fixed block slot allocator: used bits, hint, search, offset
module fbsa_dp #(
    parameter int SLOTS = fbsa_pkg::SLOTS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    input  logic [fbsa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbsa_pkg::PAY_W-1:0]        i_cfg_data,
    // input word fields
    input  logic                              i_in_cmd,
    input  logic [fbsa_pkg::SLOT_W-1:0]       i_in_slot_index,
    input  logic                              i_in_is_overflow_handle,
    // control
    input  fbsa_pkg::t_cmd                    i_cmd,
    output fbsa_pkg::t_sts                    o_sts,
    // output word
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [fbsa_pkg::STAT_W-1:0]       o_out_status,
    output logic [fbsa_pkg::SLOT_W-1:0]       o_out_granted_slot,
    output logic [fbsa_pkg::OFF_W-1:0]        o_out_data_offset
);

    localparam int GRP_W      = fbsa_pkg::GRP_W;
    localparam int LOG_GRP_W  = fbsa_pkg::LOG_GRP_W;
    localparam int TE_W       = fbsa_pkg::TE_W;
    localparam int USED_DEPTH = (SLOTS < fbsa_pkg::MAX_COUNT) ? SLOTS : fbsa_pkg::MAX_COUNT;
    localparam int GROUPS     = (USED_DEPTH + GRP_W - 1) / GRP_W;
    localparam int GIW        = $clog2(GROUPS + 1);
    localparam int HW         = $clog2(USED_DEPTH + 1);
    localparam int PW         = $clog2((GROUPS + 1) * GRP_W);
    localparam int AW         = (PW > TE_W) ? PW : TE_W;
    localparam int PROD_W     = HW + fbsa_pkg::STRIDE_W;

    // configuration registers
    logic [TE_W-1:0]                r_table_entries;
    logic [fbsa_pkg::PAY_W-1:0]     r_payload;

    // used bits, one spare group so the hint group is always addressable
    logic [GRP_W-1:0]               r_used [GROUPS+1];
    logic [HW-1:0]                  r_hint;
    logic [GIW-1:0]                 r_grp;

    // request and result holding
    logic [fbsa_pkg::SLOT_W-1:0]    r_idx;
    logic                           r_ovf;
    fbsa_pkg::t_status              r_status;
    logic [HW-1:0]                  r_slot;
    logic [PROD_W-1:0]              r_prod;

    // output register
    logic                           r_out_valid;
    fbsa_pkg::t_status              r_out_status;
    logic [fbsa_pkg::SLOT_W-1:0]    r_out_slot;
    logic [fbsa_pkg::OFF_W-1:0]     r_out_offset;

    logic [TE_W-1:0]                w_count;
    logic [GRP_W-1:0]               w_word;
    logic [AW-1:0]                  w_base;
    logic [AW-1:0]                  w_abs [GRP_W];
    logic [GRP_W-1:0]               w_cand;
    logic [LOG_GRP_W-1:0]           w_bit;
    logic                           w_found;
    logic [AW-1:0]                  w_pos;
    logic                           w_last;
    logic                           w_free_ok;
    logic                           w_in_idx_ok;
    logic [TE_W-1:0]                w_in_idx_grp;
    logic [HW-1:0]                  w_hint_grp;
    logic [GIW-1:0]                 n_grp;
    logic [fbsa_pkg::STRIDE_W-1:0]  w_stride;
    logic                           w_pool;

    // usable slot count, saturated to the pool size
    assign w_count = (r_table_entries > TE_W'(USED_DEPTH)) ? TE_W'(USED_DEPTH)
                                                          : r_table_entries;

    // current group of used bits
    assign w_word = r_used[r_grp];
    assign w_base = AW'(r_grp) << LOG_GRP_W;

    // candidate slots: free, at or above the hint, below the count
    always_comb begin
        for (int b = 0; b < GRP_W; b++) begin
            w_abs[b]  = w_base + AW'(b);
            w_cand[b] = !w_word[b] && (w_abs[b] >= AW'(r_hint))
                        && (w_abs[b] < AW'(w_count));
        end
    end

    // lowest candidate in the group
    always_comb begin
        w_bit = '0;
        for (int b = GRP_W - 1; b >= 0; b--) begin
            if (w_cand[b]) begin
                w_bit = LOG_GRP_W'(b);
            end
        end
    end

    assign w_found = |w_cand;
    assign w_pos   = w_base + AW'(w_bit);
    assign w_last  = ((AW'(r_grp) + AW'(1)) << LOG_GRP_W) >= AW'(w_count);

    // free check on the group holding the named slot
    assign w_free_ok = !r_ovf && (TE_W'(r_idx) < w_count)
                       && w_word[r_idx[LOG_GRP_W-1:0]];

    // group to start from on an accepted word
    assign w_in_idx_ok  = TE_W'(i_in_slot_index) < w_count;
    assign w_in_idx_grp = TE_W'(i_in_slot_index) >> LOG_GRP_W;
    assign w_hint_grp   = r_hint >> LOG_GRP_W;
    always_comb begin
        if (i_in_cmd == fbsa_pkg::CMD_FREE) begin
            n_grp = w_in_idx_ok ? w_in_idx_grp[GIW-1:0] : '0;
        end else begin
            n_grp = w_hint_grp[GIW-1:0];
        end
    end

    assign w_stride = fbsa_pkg::STRIDE_W'(r_payload) + fbsa_pkg::STRIDE_W'(fbsa_pkg::TAG_BYTES);
    assign w_pool   = (r_status == fbsa_pkg::ST_POOL);

    // status to the controller
    assign o_sts.in_free  = (i_in_cmd == fbsa_pkg::CMD_FREE);
    assign o_sts.found    = w_found;
    assign o_sts.last     = w_last;
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_entries <= fbsa_pkg::TE_RESET;
            r_payload       <= fbsa_pkg::PAY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fbsa_pkg::CFG_TABLE_ENTRIES: r_table_entries <= i_cfg_data[TE_W-1:0];
                fbsa_pkg::CFG_PAYLOAD_BYTES: r_payload       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // used bits and hint
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g <= GROUPS; g++) begin
                r_used[g] <= '0;
            end
            r_hint <= '0;
        end else if (i_cmd.take) begin
            r_used[r_grp][w_bit] <= 1'b1;
            r_hint <= HW'(w_pos + AW'(1));
        end else if (i_cmd.free_eval && w_free_ok) begin
            r_used[r_grp][r_idx[LOG_GRP_W-1:0]] <= 1'b0;
            if (AW'(r_hint) > AW'(r_idx)) begin
                r_hint <= HW'(r_idx);
            end
        end
    end

    // request capture, group walk and result build
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_idx <= i_in_slot_index;
            r_ovf <= i_in_is_overflow_handle;
            r_grp <= n_grp;
        end else if (i_cmd.grp_inc) begin
            r_grp <= r_grp + GIW'(1);
        end
        if (i_cmd.take) begin
            r_slot   <= HW'(w_pos);
            r_status <= fbsa_pkg::ST_POOL;
        end else if (i_cmd.ovf) begin
            r_status <= fbsa_pkg::ST_OVERFLOW;
        end else if (i_cmd.free_eval) begin
            r_status <= w_free_ok ? fbsa_pkg::ST_FREED : fbsa_pkg::ST_IGNORED;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_slot) * PROD_W'(w_stride);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_slot   <= w_pool ? fbsa_pkg::SLOT_W'(r_slot) : '0;
            r_out_offset <= w_pool ? fbsa_pkg::OFF_W'(r_prod + PROD_W'(fbsa_pkg::TAG_BYTES))
                                   : '0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_status       = r_out_status;
    assign o_out_granted_slot = r_out_slot;
    assign o_out_data_offset  = r_out_offset;

`ifndef SYNTHESIS
    // a taken slot moves the hint just past it
    a_take_hint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |=> (r_hint == HW'($past(w_pos) + AW'(1))))
        else $error("hint not moved past taken slot");

    // the hint never runs past the pool
    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        AW'(r_hint) <= AW'(USED_DEPTH))
        else $error("hint beyond pool");

    // a found slot lies below the usable count and was free
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_found |-> ((w_pos < AW'(w_count)) && !w_word[w_bit]))
        else $error("found slot out of range or used");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && i_out_stall))
        else $error("output word overwritten");
`endif

endmodule

>>> hdl/fixed_block_slot_allocator_top.sv
// Fixed block slot allocator top level: a search over used bits from a hint.
// Allocate: the used bits are searched one 16-slot group at a time from the
// hint group, then the offset is multiplied. Free: the named slot is checked.
// The next word is taken once the result is in the output register, so a
// stalled output also holds back new requests.
// Reset (synchronous, active low) clears all used bits and the hint at once.
module fixed_block_slot_allocator_top #(
    parameter int SLOTS = fbsa_pkg::SLOTS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fbsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbsa_pkg::PAY_W-1:0]      i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_in_cmd,
    input  logic [fbsa_pkg::SLOT_W-1:0]     i_in_slot_index,
    input  logic                            i_in_is_overflow_handle,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [fbsa_pkg::STAT_W-1:0]     o_out_status,
    output logic [fbsa_pkg::SLOT_W-1:0]     o_out_granted_slot,
    output logic [fbsa_pkg::OFF_W-1:0]      o_out_data_offset
);

    fbsa_pkg::t_cmd w_cmd;
    fbsa_pkg::t_sts w_sts;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    // controller
    fbsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    fbsa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_valid             (i_cfg_valid),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_in_cmd                (i_in_cmd),
        .i_in_slot_index         (i_in_slot_index),
        .i_in_is_overflow_handle (i_in_is_overflow_handle),
        .i_cmd                   (w_cmd),
        .o_sts                   (w_sts),
        .o_out_valid             (o_out_valid),
        .i_out_stall             (i_out_stall),
        .o_out_status            (o_out_status),
        .o_out_granted_slot      (o_out_granted_slot),
        .o_out_data_offset       (o_out_data_offset)
    );

endmodule

>>> tb/sv/tb_fixed_block_slot_allocator_top.sv
// testbench for the fixed block slot allocator: directed and random requests against a pool model
`timescale 1ns / 100ps

module tb_fixed_block_slot_allocator_top;

    // one expected reply word
    typedef struct packed {
        fbsa_pkg::t_status                status;
        logic [fbsa_pkg::SLOT_W-1:0]      slot;
        logic [fbsa_pkg::OFF_W-1:0]       offset;
    } t_reply;

    localparam int LONG_HOLD_CYCLES = 200;

    // clock, reset and block inputs
    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic [fbsa_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [fbsa_pkg::PAY_W-1:0]         cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_cmd = fbsa_pkg::CMD_ALLOC;
    logic [fbsa_pkg::SLOT_W-1:0]        in_slot_index = '0;
    logic                               in_ovf_handle = 1'b0;
    logic                               out_stall = 1'b0;

    // block outputs
    logic                               cfg_ready;
    logic                               in_stall;
    logic                               out_valid;
    logic [fbsa_pkg::STAT_W-1:0]        out_status;
    logic [fbsa_pkg::SLOT_W-1:0]        out_granted_slot;
    logic [fbsa_pkg::OFF_W-1:0]         out_data_offset;

    // pool model state and register copies
    logic                               model_used [fbsa_pkg::SLOTS_DEFAULT];
    int                                 model_hint;
    logic [fbsa_pkg::TE_W-1:0]          cfg_entries = fbsa_pkg::TE_RESET;
    logic [fbsa_pkg::PAY_W-1:0]         cfg_payload = fbsa_pkg::PAY_RESET;

    // replies still owed by the block, oldest first
    t_reply                             pending_replies [$];
    int                                 error_count = 0;

    // idling controls
    bit                                 tx_idle_en = 1'b1;
    bit                                 rx_idle_en = 1'b1;
    int                                 hold_requests = 0;
    int                                 hold_served = 0;
    int                                 hold_left = 0;
    int                                 rx_gap_left = 0;

    fixed_block_slot_allocator_top uut (
        .i_clk                   (clk),
        .i_rst_n                 (rst_n),
        .i_cfg_valid             (cfg_valid),
        .o_cfg_ready             (cfg_ready),
        .i_cfg_index             (cfg_index),
        .i_cfg_data              (cfg_data),
        .i_in_valid              (in_valid),
        .o_in_stall              (in_stall),
        .i_in_cmd                (in_cmd),
        .i_in_slot_index         (in_slot_index),
        .i_in_is_overflow_handle (in_ovf_handle),
        .o_out_valid             (out_valid),
        .i_out_stall             (out_stall),
        .o_out_status            (out_status),
        .o_out_granted_slot      (out_granted_slot),
        .o_out_data_offset       (out_data_offset)
    );

    always #10 clk = ~clk;

    // usable slot count, saturated at the pool size
    function automatic int usable_count();
        return (int'(cfg_entries) > fbsa_pkg::SLOTS_DEFAULT) ? fbsa_pkg::SLOTS_DEFAULT
                                                             : int'(cfg_entries);
    endfunction

    // pool model: apply one request and return the reply it causes
    function automatic t_reply predict_reply(input logic cmd,
                                             input logic [fbsa_pkg::SLOT_W-1:0] idx,
                                             input logic ovf);
        t_reply r;
        int     count;
        int     s;
        r = '{status: fbsa_pkg::ST_IGNORED, slot: '0, offset: '0};
        count = usable_count();
        if (cmd == fbsa_pkg::CMD_ALLOC) begin
            r.status = fbsa_pkg::ST_OVERFLOW;
            for (s = model_hint; s < count; s++) begin
                if (!model_used[s]) begin
                    model_used[s] = 1'b1;
                    model_hint = s + 1;
                    r.status = fbsa_pkg::ST_POOL;
                    r.slot = fbsa_pkg::SLOT_W'(s);
                    r.offset = fbsa_pkg::OFF_W'(s * (int'(cfg_payload) + fbsa_pkg::TAG_BYTES)
                                                + fbsa_pkg::TAG_BYTES);
                    break;
                end
            end
        end else if (!ovf && int'(idx) < count && model_used[idx]) begin
            model_used[idx] = 1'b0;
            if (model_hint > int'(idx))
                model_hint = int'(idx);
            r.status = fbsa_pkg::ST_FREED;
        end
        return r;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endfunction

    // reply checker
    always @(posedge clk) begin
        t_reply exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_replies.size() == 0) begin
                note_error($sformatf("unexpected reply: status %0d slot %0d offset %0d",
                                     out_status, out_granted_slot, out_data_offset));
            end else begin
                exp_r = pending_replies.pop_front();
                if (out_status !== exp_r.status || out_granted_slot !== exp_r.slot ||
                    out_data_offset !== exp_r.offset)
                    note_error($sformatf({"reply mismatch: expected status %s slot %0d ",
                                          "offset %0d, got status %0d slot %0d offset %0d"},
                                         exp_r.status.name(), exp_r.slot, exp_r.offset,
                                         out_status, out_granted_slot, out_data_offset));
            end
        end
    end

    // receiver stalls: long hold-offs on request, else random bursts
    always @(posedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            out_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            rx_gap_left = $urandom_range(1, 9) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // send one request word and record the reply it should cause
    task automatic send_request(input logic cmd, input logic [fbsa_pkg::SLOT_W-1:0] idx,
                                input logic ovf);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_cmd <= cmd;
        in_slot_index <= idx;
        in_ovf_handle <= ovf;
        do @(posedge clk); while (in_stall);
        pending_replies.push_back(predict_reply(cmd, idx, ovf));
    endtask

    // stop sending until every reply has come
    task automatic drain_replies();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_replies.size() != 0);
    endtask

    task automatic write_register(input logic [fbsa_pkg::CFG_IDX_W-1:0] index,
                                  input logic [fbsa_pkg::PAY_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (index == fbsa_pkg::CFG_TABLE_ENTRIES)
            cfg_entries = data[fbsa_pkg::TE_W-1:0];
        else
            cfg_payload = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_pool(input int entries, input int payload);
        drain_replies();
        write_register(fbsa_pkg::CFG_TABLE_ENTRIES, fbsa_pkg::PAY_W'(entries));
        write_register(fbsa_pkg::CFG_PAYLOAD_BYTES, fbsa_pkg::PAY_W'(payload));
    endtask

    // random request: mostly allocs and frees of live slots, some noise
    task automatic random_request(input int alloc_pct);
        int                          used_list [$];
        int                          count;
        logic [fbsa_pkg::SLOT_W-1:0] idx;
        logic                        ovf;
        count = usable_count();
        for (int s = 0; s < count; s++)
            if (model_used[s])
                used_list.push_back(s);
        idx = fbsa_pkg::SLOT_W'($urandom_range(0, 63));
        ovf = 1'($urandom_range(0, 1));
        if ($urandom_range(1, 100) <= alloc_pct)
            send_request(fbsa_pkg::CMD_ALLOC, idx, ovf);
        else if (used_list.size() != 0 && $urandom_range(0, 9) != 0)
            send_request(fbsa_pkg::CMD_FREE,
                         fbsa_pkg::SLOT_W'(used_list[$urandom_range(0, used_list.size() - 1)]),
                         1'b0);
        else
            send_request(fbsa_pkg::CMD_FREE, idx, ovf);
    endtask

    // default pool: grants in order, hint lowering, ignored frees
    task automatic test_basic();
        repeat (4) send_request(fbsa_pkg::CMD_ALLOC, fbsa_pkg::SLOT_W'(0), 1'b0);
        send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(1), 1'b0);
        send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(1), 1'b0);
        send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(0), 1'b1);
        send_request(fbsa_pkg::CMD_ALLOC, fbsa_pkg::SLOT_W'(63), 1'b1);
        send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(63), 1'b0);
        send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(2), 1'b0);
    endtask

    // shrunk pool: hint beyond count, out of range free, exhaustion
    task automatic test_small_pool();
        set_pool(2, 64);
        send_request(fbsa_pkg::CMD_ALLOC, fbsa_pkg::SLOT_W'(0), 1'b0);
        send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(3), 1'b0);
        send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(1), 1'b0);
        send_request(fbsa_pkg::CMD_ALLOC, fbsa_pkg::SLOT_W'(0), 1'b0);
        send_request(fbsa_pkg::CMD_ALLOC, fbsa_pkg::SLOT_W'(0), 1'b0);
        set_pool(1, 4095);
        send_request(fbsa_pkg::CMD_ALLOC, fbsa_pkg::SLOT_W'(0), 1'b0);
        send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(0), 1'b0);
        send_request(fbsa_pkg::CMD_ALLOC, fbsa_pkg::SLOT_W'(0), 1'b0);
        send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(63), 1'b1);
        set_pool(64, 1);
        send_request(fbsa_pkg::CMD_ALLOC, fbsa_pkg::SLOT_W'(0), 1'b0);
    endtask

    // fill the whole pool at the largest block size behind a long receiver hold-off
    task automatic test_full_pool();
        int live [$];
        set_pool(64, 4095);
        tx_idle_en = 1'b0;
        hold_requests++;
        repeat (66) send_request(fbsa_pkg::CMD_ALLOC,
                                 fbsa_pkg::SLOT_W'($urandom_range(0, 63)), 1'b0);
        drain_replies();
        tx_idle_en = 1'b1;
        for (int s = 0; s < fbsa_pkg::SLOTS_DEFAULT; s++)
            if (model_used[s])
                live.push_back(s);
        live.shuffle();
        foreach (live[k])
            send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(live[k]), 1'b0);
        send_request(fbsa_pkg::CMD_FREE, fbsa_pkg::SLOT_W'(63), 1'b0);
        send_request(fbsa_pkg::CMD_ALLOC, fbsa_pkg::SLOT_W'(0), 1'b0);
    endtask

    // random traffic over several pool settings, quiet at the end
    task automatic test_random_phases();
        int entries [8] = '{64, 1, 64, 37, 2, 64, 0, 64};
        int payload [8] = '{64, 4095, 1, 0, 4095, 4095, 0, 0};
        int alloc_pct [8] = '{60, 50, 70, 55, 45, 65, 50, 55};
        for (int p = 0; p < 8; p++) begin
            set_pool(entries[p] == 0 ? $urandom_range(1, 64) : entries[p],
                     payload[p] == 0 ? $urandom_range(1, 4095) : payload[p]);
            tx_idle_en = (p != 7) && (p != 2);
            rx_idle_en = (p != 7) && (p != 4);
            for (int n = 0; n < 80; n++) begin
                if ($urandom_range(0, 39) == 0)
                    drain_replies();
                random_request(alloc_pct[p]);
            end
        end
    endtask

    // main sequence
    initial begin
        int waited;
        foreach (model_used[s])
            model_used[s] = 1'b0;
        model_hint = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic();
        test_small_pool();
        test_full_pool();
        test_random_phases();
        in_valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending_replies.size() != 0 && waited < 5000);
        if (pending_replies.size() != 0)
            note_error($sformatf("%0d replies never came", pending_replies.size()));
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial begin
        #6000000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hdl/fbsa_pkg.sv
hdl/fbsa_ctrl.sv
hdl/fbsa_dp.sv
hdl/fixed_block_slot_allocator_top.sv
tb/sv/tb_fixed_block_slot_allocator_top.sv
